// ===== rtl/core/bts_pkg.sv =====
package bts_pkg;

    localparam int MAX_WIDTH = 1024;

    localparam int ROW_W   = 12;
    localparam int OUTC_W  = 10;
    localparam int WIDTH_W = 11;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(480);

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_SUBPASS_PARITY = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OUTC_W-1:0] col;
        logic              pix;
        logic              del;
        logic              last;
    } result_t;

endpackage

// ===== rtl/core/bts_line_store.sv =====
module bts_line_store #(
    parameter int DEPTH = bts_pkg::MAX_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_up,
    output logic              rd_mid,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_up,
    input  logic              wr_mid
);

    logic upper_mem [DEPTH];
    logic middle_mem [DEPTH];
    logic rd_up_reg;
    logic rd_mid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_up;
            middle_mem[wr_addr] <= wr_mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_up_reg  <= upper_mem[rd_addr];
            rd_mid_reg <= middle_mem[rd_addr];
        end
    end

    assign rd_up  = rd_up_reg;
    assign rd_mid = rd_mid_reg;

endmodule

// ===== rtl/core/bts_kernel.sv =====
module bts_kernel #(
    parameter int COL_W = 10
) (
    input  logic [bts_pkg::ROW_W-1:0] row,
    input  logic [COL_W-1:0]          col,
    input  logic                      pix,
    input  logic                      up,
    input  logic                      mid,
    input  logic [5:0]                win,
    input  logic                      parity,
    input  logic [COL_W-1:0]          last_col,
    input  logic [bts_pkg::ROW_W-1:0] last_row,
    output bts_pkg::result_t          res [3],
    output logic [1:0]                count
);

    logic [2:0]       lc;
    logic [2:0]       cc;
    logic [2:0]       rc;
    logic [7:0]       ring;
    logic [7:0]       rises;
    logic [3:0]       set_cnt;
    logic             m1;
    logic             m2;
    logic             clear_ok;
    logic             del;
    logic             v0;
    logic             v1;
    logic             v2;
    logic             row_ok;
    logic             col_ok;
    bts_pkg::result_t e0;
    bts_pkg::result_t e1;
    bts_pkg::result_t e2;

    assign cc = win[2:0];
    assign lc = win[5:3];
    assign rc = {pix, mid, up};

    // Neighbours clockwise from north: P2 P3 P4 P5 P6 P7 P8 P9.
    assign ring = {lc[0], lc[1], lc[2], cc[2], rc[2], rc[1], rc[0], cc[0]};
    assign rises = ~ring & {ring[0], ring[7:1]};
    assign set_cnt = 4'($countones(ring));

    always_comb
    begin
        if (parity)
        begin
            m1 = cc[0] & rc[1] & lc[1];
            m2 = cc[0] & cc[2] & lc[1];
        end
        else
        begin
            m1 = cc[0] & rc[1] & cc[2];
            m2 = rc[1] & cc[2] & lc[1];
        end
    end

    assign clear_ok = cc[1] && ($countones(rises) == 1) && (set_cnt >= 4'd2)
                      && (set_cnt <= 4'd6) && !m1 && !m2;

    assign row_ok = (row != '0);
    assign col_ok = (col != '0);
    assign del = clear_ok && (row >= bts_pkg::ROW_W'(2)) && (col >= COL_W'(2));

    assign v0 = row_ok && col_ok;
    assign v1 = row_ok && (col == last_col);
    assign v2 = (row == last_row);

    always_comb
    begin
        e0.row  = row - bts_pkg::ROW_W'(1);
        e0.col  = bts_pkg::OUTC_W'(col - COL_W'(1));
        e0.pix  = cc[1] & ~del;
        e0.del  = del;
        e0.last = !v1 && !v2;

        e1.row  = row - bts_pkg::ROW_W'(1);
        e1.col  = bts_pkg::OUTC_W'(col);
        e1.pix  = mid;
        e1.del  = 1'b0;
        e1.last = !v2;

        e2.row  = row;
        e2.col  = bts_pkg::OUTC_W'(col);
        e2.pix  = pix;
        e2.del  = 1'b0;
        e2.last = 1'b1;
    end

    // Results are packed to the front in emission order.
    always_comb
    begin
        res[0] = e0;
        res[1] = e1;
        res[2] = e2;
        if (!v0)
        begin
            res[0] = v1 ? e1 : e2;
            res[1] = e2;
        end
        else if (!v1)
        begin
            res[1] = e2;
        end
        count = 2'({1'b0, v0} + {1'b0, v1} + {1'b0, v2});
    end

endmodule

// ===== rtl/core/bts_out_queue.sv =====
module bts_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bts_pkg::result_t load_res [3],
    input  logic [1:0]       load_count,
    output logic             free,
    output logic             valid,
    input  logic             stall,
    output bts_pkg::result_t head
);

    bts_pkg::result_t slot_reg [3];
    bts_pkg::result_t slot_next [3];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             take;

    assign valid = (count_reg != 2'd0);
    assign take  = valid && !stall;
    assign free  = (count_reg == 2'd0) || ((count_reg == 2'd1) && take);
    assign head  = slot_reg[0];

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (load)
        begin
            slot_next  = load_res;
            count_next = load_count;
        end
        else if (take)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            count_next   = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== rtl/core/binary_thinning_subpass.sv =====
// One sub-pass of two-sub-pass parallel thinning on a binary image streamed in raster order,
// one pixel per beat. A pixel is accepted every cycle while results drain at the same pace;
// each pixel normally yields one result (the window centre one row and one column behind it),
// but the last pixel of a row adds the last column of the previous row, and every pixel of the
// last row adds itself, so up to three results leave in turn through a three-entry result
// queue and the input stalls there while the queue drains. Each pixel is registered with its
// line-store read, then its results pass through the result queue. Writing image_width or
// image_height restarts the frame at row 0, column 0; parity takes effect at once. Registers
// must be written only while no pixel is in flight; the block itself does not enforce it.
module binary_thinning_subpass #(
    parameter int MAX_WIDTH = bts_pkg::MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          pixel_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bts_pkg::ROW_W-1:0]     out_row,
    output logic [bts_pkg::OUTC_W-1:0]    out_col,
    output logic                          pixel_out,
    output logic                          was_deleted,
    output logic                          last_of_run,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bts_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bts_pkg::CFG_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > bts_pkg::WIDTH_W) ? COL_W + 1 : bts_pkg::WIDTH_W;

    logic [bts_pkg::WIDTH_W-1:0] width_reg;
    logic [bts_pkg::ROW_W-1:0]   height_reg;
    logic                        parity_reg;
    logic [bts_pkg::ROW_W-1:0]   row_count_reg;
    logic [bts_pkg::ROW_W-1:0]   row_count_next;
    logic [COL_W-1:0]            col_count_reg;
    logic [COL_W-1:0]            col_count_next;
    logic [5:0]                  win_reg;
    logic [5:0]                  win_next;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_pix_reg;
    logic [bts_pkg::ROW_W-1:0]   s1_row_reg;
    logic [COL_W-1:0]            s1_col_reg;

    logic [CMP_W-1:0]            width_ext;
    logic [COL_W-1:0]            last_col;
    logic [bts_pkg::ROW_W-1:0]   last_row;
    logic                        accept;
    logic                        cfg_write;
    logic                        size_write;
    logic                        s1_go;
    logic                        rd_up;
    logic                        rd_mid;
    logic                        q_free;
    bts_pkg::result_t            k_res [3];
    logic [1:0]                  k_count;
    bts_pkg::result_t            q_head;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign size_write = cfg_write && ((cfg_index == bts_pkg::REG_IMAGE_WIDTH)
                                   || (cfg_index == bts_pkg::REG_IMAGE_HEIGHT));

    // Width saturates to [3, MAX_WIDTH], height to at least 3.
    assign width_ext = CMP_W'(width_reg);
    always_comb
    begin
        if (width_ext < CMP_W'(3))
        begin
            last_col = COL_W'(2);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(width_ext - CMP_W'(1));
        end
    end

    assign last_row = (height_reg < bts_pkg::ROW_W'(3)) ? bts_pkg::ROW_W'(2)
                                                        : height_reg - bts_pkg::ROW_W'(1);

    // An item with no results never waits for the queue.
    assign s1_go    = s1_valid_reg && ((k_count == 2'd0) || q_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (size_write)
        begin
            row_count_next = '0;
            col_count_next = '0;
        end
        else if (accept)
        begin
            if (col_count_reg == last_col)
            begin
                col_count_next = '0;
                row_count_next = (row_count_reg == last_row) ? '0
                                 : row_count_reg + bts_pkg::ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        win_next = win_reg;
        if (size_write)
        begin
            win_next = '0;
        end
        else if (s1_go)
        begin
            win_next = {win_reg[2:0], s1_pix_reg, rd_mid, rd_up};
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= bts_pkg::WIDTH_RESET;
            height_reg    <= bts_pkg::HEIGHT_RESET;
            parity_reg    <= 1'b0;
            row_count_reg <= '0;
            col_count_reg <= '0;
            win_reg       <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    bts_pkg::REG_IMAGE_WIDTH:    width_reg  <= cfg_data[bts_pkg::WIDTH_W-1:0];
                    bts_pkg::REG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                    bts_pkg::REG_SUBPASS_PARITY: parity_reg <= cfg_data[0];
                    default:                     ;
                endcase
            end
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            win_reg       <= win_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixel_in;
            s1_row_reg <= row_count_reg;
            s1_col_reg <= col_count_reg;
        end
    end

    // The read for a column and the write-back of the column before it never share an address.
    bts_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .rd_up   (rd_up),
        .rd_mid  (rd_mid),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_up   (rd_mid),
        .wr_mid  (s1_pix_reg)
    );

    bts_kernel #(
        .COL_W (COL_W)
    ) u_kernel (
        .row      (s1_row_reg),
        .col      (s1_col_reg),
        .pix      (s1_pix_reg),
        .up       (rd_up),
        .mid      (rd_mid),
        .win      (win_reg),
        .parity   (parity_reg),
        .last_col (last_col),
        .last_row (last_row),
        .res      (k_res),
        .count    (k_count)
    );

    bts_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_go && (k_count != 2'd0)),
        .load_res   (k_res),
        .load_count (k_count),
        .free       (q_free),
        .valid      (out_valid),
        .stall      (out_stall),
        .head       (q_head)
    );

    assign out_row     = q_head.row;
    assign out_col     = q_head.col;
    assign pixel_out   = q_head.pix;
    assign was_deleted = q_head.del;
    assign last_of_run = q_head.last;

endmodule

// ===== sim/tb_binary_thinning_subpass.sv =====
module tb_binary_thinning_subpass;
    import bts_pkg::*;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // One row of the directed script: the pixel to send and, where typed is set,
    // the results written out by hand in place of the predicted ones.
    typedef struct packed {
        logic       pix;
        logic       typed;
        logic [1:0] nwant;
        result_t    w0;
        result_t    w1;
        result_t    w2;
    } pattern_t;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_PHASE  = 2;
    localparam int N_SCRIPT    = 20;
    localparam int N_PHASES    = 8;

    localparam result_t NO_PX = '0;

    // Register values as written; a width of 2 and a height of 1 saturate to 3, and 3072
    // has bit 11 set, which the width register drops, leaving exactly 1024.
    localparam int PH_W    [N_PHASES] = '{5, 7, 4, 6, 2, 3, 3072, 9};
    localparam int PH_H    [N_PHASES] = '{4, 5, 6, 3, 1, 4095, 3, 4};
    localparam int PH_PAR  [N_PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0};
    localparam int PH_N    [N_PHASES] = '{27, 35, 24, 18, 12, 15, 12, 36};
    localparam int PH_DENS [N_PHASES] = '{50, 35, 65, 50, 50, 45, 55, 80};

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic                pixel_in    = 1'b0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [ROW_W-1:0]    out_row;
    logic [OUTC_W-1:0]   out_col;
    logic                pixel_out;
    logic                was_deleted;
    logic                last_of_run;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_W-1:0]    cfg_data    = '0;

    idle_mode_t          idle_mode   = IDLE_NONE;
    int                  phase_no    = -1;
    int                  n_fail      = 0;
    int                  cycle_n     = 0;
    int                  hold_left   = 0;
    bit                  hold_done   = 1'b0;

    // Predictor state.
    result_t             pending_pixels [$];
    bit                  upper_store [MAX_WIDTH];
    bit                  middle_store [MAX_WIDTH];
    logic [5:0]          window      = '0;
    int                  row_n       = 0;
    int                  col_n       = 0;
    logic [WIDTH_W-1:0]  width_reg   = WIDTH_RESET;
    logic [ROW_W-1:0]    height_reg  = HEIGHT_RESET;
    logic                parity_reg  = 1'b0;

    binary_thinning_subpass dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .out_col     (out_col),
        .pixel_out   (pixel_out),
        .was_deleted (was_deleted),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic result_t px(input int r, input int c, input logic p, input logic d,
                                   input logic l);
        result_t x;
        x.row  = ROW_W'(r);
        x.col  = OUTC_W'(c);
        x.pix  = p;
        x.del  = d;
        x.last = l;
        return x;
    endfunction

    function automatic pattern_t pat(input logic p, input logic t, input int n,
                                     input result_t a, input result_t b, input result_t c);
        pattern_t x;
        x.pix   = p;
        x.typed = t;
        x.nwant = 2'(n);
        x.w0    = a;
        x.w1    = b;
        x.w2    = c;
        return x;
    endfunction

    function automatic int idle_pct(input logic sender);
        if (idle_mode == IDLE_BOTH)
            return 34;
        if ((sender && idle_mode == IDLE_SEND) || (!sender && idle_mode == IDLE_RECV))
            return 53;
        return 0;
    endfunction

    // Window columns hold {new, middle, upper} rows; the ring runs P2..P9 clockwise
    // from north.
    function automatic logic deletable(input logic [2:0] lc, input logic [2:0] cc,
                                       input logic [2:0] rc);
        logic [7:0] ring;
        int         trans;
        int         cnt;
        logic       m1;
        logic       m2;
        ring  = {lc[0], lc[1], lc[2], cc[2], rc[2], rc[1], rc[0], cc[0]};
        trans = 0;
        cnt   = 0;
        for (int k = 0; k < 8; k++)
        begin
            if (!ring[k] && ring[(k + 1) % 8])
                trans++;
            cnt += ring[k];
        end
        if (parity_reg)
        begin
            m1 = ring[0] & ring[2] & ring[6];
            m2 = ring[0] & ring[4] & ring[6];
        end
        else
        begin
            m1 = ring[0] & ring[2] & ring[4];
            m2 = ring[2] & ring[4] & ring[6];
        end
        return cc[1] && trans == 1 && cnt >= 2 && cnt <= 6 && !m1 && !m2;
    endfunction

    task automatic thin_step(input logic pix, output int n, output result_t o0,
                             output result_t o1, output result_t o2);
        result_t    made [3];
        int         w;
        int         h;
        int         r;
        int         c;
        logic       up;
        logic       mid;
        logic       del;
        logic [2:0] newcol;
        logic [2:0] cc;
        logic [2:0] lc;
        w = int'(width_reg);
        if (w < 3)
            w = 3;
        else if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = int'(height_reg);
        if (h < 3)
            h = 3;
        r      = row_n;
        c      = col_n;
        up     = upper_store[c];
        mid    = middle_store[c];
        newcol = {pix, mid, up};
        cc     = window[2:0];
        lc     = window[5:3];
        n      = 0;
        if (r >= 1 && c >= 1)
        begin
            del     = (r >= 2 && c >= 2) ? deletable(lc, cc, newcol) : 1'b0;
            made[n] = px(r - 1, c - 1, cc[1] & ~del, del, 1'b0);
            n++;
        end
        if (r >= 1 && c == w - 1)
        begin
            made[n] = px(r - 1, c, mid, 1'b0, 1'b0);
            n++;
        end
        // The last row is passed straight through as it arrives.
        if (r == h - 1)
        begin
            made[n] = px(r, c, pix, 1'b0, 1'b0);
            n++;
        end
        if (n > 0)
            made[n - 1].last = 1'b1;
        upper_store[c]  = mid;
        middle_store[c] = pix;
        window          = {cc, newcol};
        if (c + 1 >= w)
        begin
            col_n = 0;
            row_n = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_n = c + 1;
        o0 = made[0];
        o1 = made[1];
        o2 = made[2];
    endtask

    task automatic flag_mismatch(input string msg);
        n_fail++;
        if (n_fail <= 40)
            $display("mismatch: %s", msg);
    endtask

    task automatic feed_pixel(input pattern_t d);
        result_t made [3];
        int      n;
        thin_step(d.pix, n, made[0], made[1], made[2]);
        if (d.typed)
        begin
            n       = d.nwant;
            made[0] = d.w0;
            made[1] = d.w1;
            made[2] = d.w2;
        end
        for (int k = 0; k < n; k++)
            pending_pixels = {pending_pixels, made[k]};
        while ($urandom_range(99) < idle_pct(1'b1))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= d.pix;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Pixels without a result may still be in flight once the queue is empty, so the task
    // waits out the SETTLE period before the block counts as idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:
            begin
                width_reg = val[WIDTH_W-1:0];
                row_n     = 0;
                col_n     = 0;
                window    = '0;
            end
            REG_IMAGE_HEIGHT:
            begin
                height_reg = val[ROW_W-1:0];
                row_n      = 0;
                col_n      = 0;
                window     = '0;
            end
            REG_SUBPASS_PARITY:
                parity_reg = val[0];
            default:
                ;
        endcase
    endtask

    task automatic set_geometry(input int w, input int h, input int p);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        write_reg(REG_SUBPASS_PARITY, CFG_W'(p));
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_n);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_side
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
                flag_mismatch($sformatf("unexpected beat for pixel (%0d,%0d)",
                                        out_row, out_col));
            else
            begin
                want = pending_pixels.pop_front();
                if (out_row !== want.row)
                    flag_mismatch($sformatf("(%0d,%0d) out_row %0d", want.row, want.col,
                                            out_row));
                if (out_col !== want.col)
                    flag_mismatch($sformatf("(%0d,%0d) out_col %0d", want.row, want.col,
                                            out_col));
                if (pixel_out !== want.pix)
                    flag_mismatch($sformatf("(%0d,%0d) pixel_out %b, want %b", want.row,
                                            want.col, pixel_out, want.pix));
                if (was_deleted !== want.del)
                    flag_mismatch($sformatf("(%0d,%0d) was_deleted %b, want %b", want.row,
                                            want.col, was_deleted, want.del));
                if (last_of_run !== want.last)
                    flag_mismatch($sformatf("(%0d,%0d) last_of_run %b, want %b", want.row,
                                            want.col, last_of_run, want.last));
            end
        end
    end

    // A long hold-off once, so that the block fills up and stalls its input.
    always @(posedge clk)
    begin : hold_side
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (phase_no == HOLD_PHASE && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end

    initial
    begin
        pattern_t script [N_SCRIPT];
        pattern_t one;

        // After reset the frame is 640 by 480, so row 0 yields nothing yet.
        script[0]  = pat(1'b1, 1'b1, 0, NO_PX, NO_PX, NO_PX);
        script[1]  = pat(1'b0, 1'b1, 0, NO_PX, NO_PX, NO_PX);
        // 3x3 image 000/110/110 in the first sub-pass: the centre is cleared, and the
        // last pixel of the image yields three beats.
        script[2]  = pat(1'b0, 1'b1, 0, NO_PX, NO_PX, NO_PX);
        script[3]  = pat(1'b0, 1'b1, 0, NO_PX, NO_PX, NO_PX);
        script[4]  = pat(1'b0, 1'b1, 0, NO_PX, NO_PX, NO_PX);
        script[5]  = pat(1'b1, 1'b1, 0, NO_PX, NO_PX, NO_PX);
        script[6]  = pat(1'b1, 1'b1, 1, px(0, 0, 0, 0, 1), NO_PX, NO_PX);
        script[7]  = pat(1'b0, 1'b1, 2, px(0, 1, 0, 0, 0), px(0, 2, 0, 0, 1), NO_PX);
        script[8]  = pat(1'b1, 1'b1, 1, px(2, 0, 1, 0, 1), NO_PX, NO_PX);
        script[9]  = pat(1'b1, 1'b1, 2, px(1, 0, 1, 0, 0), px(2, 1, 1, 0, 1), NO_PX);
        script[10] = pat(1'b0, 1'b1, 3, px(1, 1, 0, 1, 0), px(1, 2, 0, 0, 0),
                         px(2, 2, 0, 0, 1));
        // 111/111/000 in the second sub-pass, with sizes written out of range: the
        // centre would go in the first sub-pass but stays here.
        script[11] = pat(1'b1, 1'b0, 0, NO_PX, NO_PX, NO_PX);
        script[12] = pat(1'b1, 1'b0, 0, NO_PX, NO_PX, NO_PX);
        script[13] = pat(1'b1, 1'b0, 0, NO_PX, NO_PX, NO_PX);
        script[14] = pat(1'b1, 1'b0, 0, NO_PX, NO_PX, NO_PX);
        script[15] = pat(1'b1, 1'b0, 0, NO_PX, NO_PX, NO_PX);
        script[16] = pat(1'b1, 1'b0, 0, NO_PX, NO_PX, NO_PX);
        script[17] = pat(1'b0, 1'b0, 0, NO_PX, NO_PX, NO_PX);
        script[18] = pat(1'b0, 1'b0, 0, NO_PX, NO_PX, NO_PX);
        script[19] = pat(1'b0, 1'b0, 0, NO_PX, NO_PX, NO_PX);

        repeat (7) @(posedge clk);
        rst_n     <= 1'b1;
        idle_mode <= IDLE_BOTH;
        @(posedge clk);

        for (int i = 0; i < N_SCRIPT; i++)
        begin
            if (i == 2)
                set_geometry(3, 3, 0);
            else if (i == 11)
                set_geometry('h800, 2, 1);
            feed_pixel(script[i]);
        end

        // Random frames; the first one stops part-way so the next size write restarts
        // a frame in progress.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_geometry(PH_W[ph], PH_H[ph], PH_PAR[ph]);
            phase_no <= ph;
            for (int k = 0; k < PH_N[ph]; k++)
            begin
                if (k % 25 == 0)
                    idle_mode <= idle_mode_t'((ph + k / 25) % 4);
                one     = '0;
                one.pix = ($urandom_range(99) < PH_DENS[ph]);
                feed_pixel(one);
            end
        end

        wait_idle();
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
